[rtl/espc_pkg.sv]
// ----------------------------------------------------------------------------
// Engine start panel controller package
// Shared types and constants for the panel controller and its channels.
// ----------------------------------------------------------------------------
package espc_pkg;

   localparam int unsigned TickWidth    = 32;
   localparam int unsigned ElapsedWidth = TickWidth + 1;
   localparam int unsigned CsrIdxWidth  = 1;

   localparam logic [TickWidth-1:0] BrightReset = TickWidth'(60000);
   localparam logic [TickWidth-1:0] DimReset    = TickWidth'(60000);

   typedef enum logic [1:0] {
      OP_GLOW  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_GLOW  = 2'd1,
      MODE_START = 2'd2,
      MODE_STOP  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_BRIGHT   = 2'd0,
      PH_DIM      = 2'd1,
      PH_DISABLED = 2'd2
   } phase_type;

   typedef logic [1:0] level_type;

   localparam level_type LV_OFF    = 2'd0;
   localparam level_type LV_DIM    = 2'd1;
   localparam level_type LV_BRIGHT = 2'd2;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_BRIGHT_TICKS = 1'b0,
      CSR_DIM_TICKS    = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic      relay_panel;
      logic      relay_glow;
      logic      relay_start;
      logic      relay_stop;
      level_type led_power;
      level_type led_glow;
      level_type led_start;
      level_type led_stop;
      logic      fade;
   } rsp_type;

endpackage

[rtl/espc_req_if.sv]
// ----------------------------------------------------------------------------
// Panel event channel
// Carries button and tick events into the panel controller.
// ----------------------------------------------------------------------------
interface espc_req_if;
   import espc_pkg::*;

   logic   valid;
   logic   ready;
   op_type operation;
   logic   pressed;

   modport source (output valid, output operation, output pressed, input ready);
   modport sink   (input valid, input operation, input pressed, output ready);

endinterface

[rtl/espc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Panel result channel
// Carries relay and LED levels out of the panel controller.
// ----------------------------------------------------------------------------
interface espc_rsp_if;
   import espc_pkg::*;

   logic      valid;
   logic      ready;
   logic      relay_panel;
   logic      relay_glow;
   logic      relay_start;
   logic      relay_stop;
   level_type led_power;
   level_type led_glow;
   level_type led_start;
   level_type led_stop;
   logic      fade;

   modport source (output valid, output relay_panel, output relay_glow,
                   output relay_start, output relay_stop, output led_power,
                   output led_glow, output led_start, output led_stop,
                   output fade, input ready);
   modport sink   (input valid, input relay_panel, input relay_glow,
                   input relay_start, input relay_stop, input led_power,
                   input led_glow, input led_start, input led_stop,
                   input fade, output ready);

endinterface

[rtl/engine_start_panel_controller.sv]
// ----------------------------------------------------------------------------
// Engine start panel controller
// Path: an accepted beat is held in the input register and decoded from there;
// its result beat (if any) goes into the result register that drives the result channel.
// Throughput: one event beat per cycle, limited only by the result channel.
// Reset: synchronous, active high; mode idle, phase bright, tick counter zero,
// both tick thresholds back to 60000.
// ----------------------------------------------------------------------------
module engine_start_panel_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   espc_req_if.sink                               req_bus,
   espc_rsp_if.source                             rsp_bus,
   input  logic                                   csr_we,
   input  logic [espc_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [espc_pkg::TickWidth-1:0]         csr_wdata
);
   import espc_pkg::*;

   // Idle LED levels follow the phase.
   function automatic rsp_type idle_result(input phase_type ph, input logic fd);
      rsp_type r;
      r = '0;
      unique case (ph)
         PH_BRIGHT: begin
            r.led_power = LV_BRIGHT;
            r.led_glow  = LV_BRIGHT;
            r.led_start = LV_BRIGHT;
            r.led_stop  = LV_BRIGHT;
         end
         PH_DIM: begin
            r.led_power = LV_DIM;
            r.led_glow  = LV_DIM;
            r.led_start = LV_DIM;
            r.led_stop  = LV_DIM;
         end
         default: begin
            r.led_power = LV_DIM;
            r.led_glow  = LV_OFF;
            r.led_start = LV_OFF;
            r.led_stop  = LV_DIM;
         end
      endcase
      r.fade = fd;
      return r;
   endfunction

   // Configuration. The bright-plus-dim sum is kept in its own register so
   // that the tick path only has to compare.
   logic [TickWidth-1:0]    bright_ff, dim_ff;
   logic [ElapsedWidth-1:0] total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= BrightReset;
         dim_ff    <= DimReset;
         total_ff  <= {1'b0, BrightReset} + {1'b0, DimReset};
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BRIGHT_TICKS: begin
               bright_ff <= csr_wdata;
               total_ff  <= {1'b0, csr_wdata} + {1'b0, dim_ff};
            end
            CSR_DIM_TICKS: begin
               dim_ff   <= csr_wdata;
               total_ff <= {1'b0, bright_ff} + {1'b0, csr_wdata};
            end
            default: ;
         endcase
      end
   end

   // Input register. It refills in the same cycle it is drained, so a new
   // beat can come in every cycle while the result register keeps moving.
   logic   in_vld_ff;
   op_type in_op_ff;
   logic   in_pressed_ff;
   logic   out_vld_ff;
   logic   out_free;
   logic   fire;

   assign out_free      = !out_vld_ff || rsp_bus.ready;
   assign fire          = in_vld_ff && out_free;
   assign req_bus.ready = !in_vld_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_op_ff      <= req_bus.operation;
         in_pressed_ff <= req_bus.pressed;
      end
   end

   // Panel state.
   mode_type                mode_ff, mode_in;
   phase_type               phase_ff, phase_in;
   logic [ElapsedWidth-1:0] elapsed_ff, elapsed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         phase_ff   <= PH_BRIGHT;
         elapsed_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // Event decode. A result is produced on every mode change, and on a phase
   // change while the panel sits idle.
   logic      hit;
   rsp_type   res;
   phase_type target;
   logic      enabled;

   assign enabled = (phase_ff != PH_DISABLED);

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      hit        = 1'b0;
      res        = '0;
      target     = PH_BRIGHT;
      if (fire) begin
         unique case (in_op_ff)
            OP_TICK: begin
               if (elapsed_ff != '1) begin
                  elapsed_in = elapsed_ff + ElapsedWidth'(1);
               end
               // Disabled wins when both thresholds are reached together.
               if (elapsed_in >= total_ff) begin
                  target = PH_DISABLED;
               end else if (elapsed_in >= {1'b0, bright_ff}) begin
                  target = PH_DIM;
               end else begin
                  target = PH_BRIGHT;
               end
               if (target > phase_ff) begin
                  phase_in = target;
                  if (mode_ff == MODE_IDLE) begin
                     hit = 1'b1;
                     res = idle_result(target, 1'b1);
                  end
               end
            end
            OP_GLOW: begin
               if (in_pressed_ff && mode_ff == MODE_IDLE && enabled) begin
                  hit             = 1'b1;
                  mode_in         = MODE_GLOW;
                  res.relay_panel = 1'b1;
                  res.relay_glow  = 1'b1;
                  res.led_glow    = LV_BRIGHT;
               end else if (!in_pressed_ff && mode_ff == MODE_GLOW) begin
                  hit     = 1'b1;
                  mode_in = MODE_IDLE;
                  res     = idle_result(phase_ff, 1'b0);
               end
            end
            OP_START: begin
               if (in_pressed_ff && mode_ff == MODE_IDLE && enabled) begin
                  hit             = 1'b1;
                  mode_in         = MODE_START;
                  res.relay_panel = 1'b1;
                  res.relay_glow  = 1'b1;
                  res.relay_start = 1'b1;
                  res.led_start   = LV_BRIGHT;
               end else if (!in_pressed_ff && mode_ff == MODE_START) begin
                  hit     = 1'b1;
                  mode_in = MODE_IDLE;
                  res     = idle_result(phase_ff, 1'b0);
               end
            end
            default: begin
               // Stop is honored in every phase.
               if (in_pressed_ff && mode_ff == MODE_IDLE) begin
                  hit            = 1'b1;
                  mode_in        = MODE_STOP;
                  res.relay_stop = 1'b1;
                  res.led_power  = (phase_ff == PH_BRIGHT) ? LV_BRIGHT : LV_DIM;
                  res.led_stop   = LV_BRIGHT;
               end else if (!in_pressed_ff && mode_ff == MODE_STOP) begin
                  hit     = 1'b1;
                  mode_in = MODE_IDLE;
                  res     = idle_result(phase_ff, 1'b0);
               end
            end
         endcase
      end
   end

   // Result register.
   rsp_type out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= fire && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && hit) begin
         out_data_ff <= res;
      end
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.relay_panel = out_data_ff.relay_panel;
   assign rsp_bus.relay_glow  = out_data_ff.relay_glow;
   assign rsp_bus.relay_start = out_data_ff.relay_start;
   assign rsp_bus.relay_stop  = out_data_ff.relay_stop;
   assign rsp_bus.led_power   = out_data_ff.led_power;
   assign rsp_bus.led_glow    = out_data_ff.led_glow;
   assign rsp_bus.led_start   = out_data_ff.led_start;
   assign rsp_bus.led_stop    = out_data_ff.led_stop;
   assign rsp_bus.fade        = out_data_ff.fade;

endmodule

[sim/espc_checker.sv]
// ----------------------------------------------------------------------------
// Engine start panel checker
// Watches the event and result channels of the panel controller. It predicts
// the result beat of every accepted event and compares each accepted result
// beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module espc_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   espc_req_if                                    req_bus,
   espc_rsp_if                                    rsp_bus,
   input  logic                                   csr_we,
   input  logic [espc_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [espc_pkg::TickWidth-1:0]         csr_wdata,
   output int                                     failures,
   output int                                     pending
);
   import espc_pkg::*;

   localparam int PrintCap = 40;

   logic [TickWidth-1:0]    bright_limit;
   logic [TickWidth-1:0]    dim_limit;
   mode_type                panel_mode;
   phase_type               panel_phase;
   logic [ElapsedWidth-1:0] ticks_elapsed;
   rsp_type                 expected_beats[$];
   int                      beat_index;

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= PrintCap) $display("MISMATCH at result beat %0d: %s", beat_index, msg);
   endtask

   task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
      if (got !== want) log_failure($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   task automatic check_flag(input string name, input logic got, input logic want);
      if (got !== want) log_failure($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   // Idle LED levels follow the phase.
   function automatic rsp_type idle_levels(input logic fade_flag);
      rsp_type beat;
      beat = '0;
      case (panel_phase)
         PH_BRIGHT: begin
            beat.led_power = LV_BRIGHT;
            beat.led_glow  = LV_BRIGHT;
            beat.led_start = LV_BRIGHT;
            beat.led_stop  = LV_BRIGHT;
         end
         PH_DIM: begin
            beat.led_power = LV_DIM;
            beat.led_glow  = LV_DIM;
            beat.led_start = LV_DIM;
            beat.led_stop  = LV_DIM;
         end
         default: begin
            beat.led_power = LV_DIM;
            beat.led_stop  = LV_DIM;
         end
      endcase
      beat.fade = fade_flag;
      return beat;
   endfunction

   // Advances the panel state by one event; returns 1 when a result beat is due.
   function automatic logic predict_panel(input op_type op, input logic pressed,
                                          output rsp_type beat);
      logic [ElapsedWidth-1:0] total;
      phase_type               target;
      mode_type                held;
      logic                    made;
      made = 1'b0;
      beat = '0;
      case (op) inside
         OP_TICK: begin
            total = ElapsedWidth'(bright_limit) + ElapsedWidth'(dim_limit);
            if (ticks_elapsed != '1) ticks_elapsed = ticks_elapsed + ElapsedWidth'(1);
            if (ticks_elapsed >= total) target = PH_DISABLED;
            else if (ticks_elapsed >= ElapsedWidth'(bright_limit)) target = PH_DIM;
            else target = PH_BRIGHT;
            if (target > panel_phase) begin
               panel_phase = target;
               if (panel_mode == MODE_IDLE) begin
                  beat = idle_levels(1'b1);
                  made = 1'b1;
               end
            end
         end
         OP_GLOW, OP_START: begin
            if (op == OP_GLOW) held = MODE_GLOW;
            else held = MODE_START;
            if (pressed && panel_mode == MODE_IDLE && panel_phase != PH_DISABLED) begin
               beat.relay_panel = 1'b1;
               beat.relay_glow  = 1'b1;
               if (op == OP_GLOW) begin
                  beat.led_glow = LV_BRIGHT;
               end else begin
                  beat.relay_start = 1'b1;
                  beat.led_start   = LV_BRIGHT;
               end
               panel_mode = held;
               made = 1'b1;
            end else if (!pressed && panel_mode == held) begin
               beat = idle_levels(1'b0);
               panel_mode = MODE_IDLE;
               made = 1'b1;
            end
         end
         default: begin
            if (pressed && panel_mode == MODE_IDLE) begin
               beat.relay_stop = 1'b1;
               beat.led_power  = (panel_phase == PH_BRIGHT) ? LV_BRIGHT : LV_DIM;
               beat.led_stop   = LV_BRIGHT;
               panel_mode = MODE_STOP;
               made = 1'b1;
            end else if (!pressed && panel_mode == MODE_STOP) begin
               beat = idle_levels(1'b0);
               panel_mode = MODE_IDLE;
               made = 1'b1;
            end
         end
      endcase
      return made;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         bright_limit  = BrightReset;
         dim_limit     = DimReset;
         panel_mode    = MODE_IDLE;
         panel_phase   = PH_BRIGHT;
         ticks_elapsed = '0;
         beat_index    = 0;
         expected_beats.delete();
         failures      = 0;
         pending      <= 0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_BRIGHT_TICKS: bright_limit = csr_wdata;
               CSR_DIM_TICKS:    dim_limit    = csr_wdata;
               default: ;
            endcase
         end
         // Results always leave later than their event is taken, so the result
         // side is settled before this edge's event is predicted.
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_beats.size() == 0) begin
               log_failure("result beat with no event waiting for it");
            end else begin
               want = expected_beats.pop_front();
               check_flag("relay_panel",  rsp_bus.relay_panel, want.relay_panel);
               check_flag("relay_glow",   rsp_bus.relay_glow,  want.relay_glow);
               check_flag("relay_start",  rsp_bus.relay_start, want.relay_start);
               check_flag("relay_stop",   rsp_bus.relay_stop,  want.relay_stop);
               check_field("led_power",   rsp_bus.led_power,   want.led_power);
               check_field("led_glow",    rsp_bus.led_glow,    want.led_glow);
               check_field("led_start",   rsp_bus.led_start,   want.led_start);
               check_field("led_stop",    rsp_bus.led_stop,    want.led_stop);
               check_flag("fade",         rsp_bus.fade,        want.fade);
            end
            beat_index++;
         end
         if (req_bus.valid && req_bus.ready) begin
            if (predict_panel(req_bus.operation, req_bus.pressed, want))
               expected_beats.push_back(want);
         end
         pending <= expected_beats.size();
      end
   end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Engine start panel controller testbench
// Drives button and tick beats into the controller, with random gaps on the
// event side and random stalls on the result side, and walks the panel
// through its bright, dim and disabled phases by moving the tick thresholds.
// A checker module beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
   import espc_pkg::*;

   // Cycles to let pass after the last expected result before touching the
   // thresholds or ending the run.
   localparam int SettleCycles = 8;
   // The watchdog gives up after this many cycles without any accepted beat.
   // The worst legal quiet stretch is the long receiver hold-off below.
   localparam int StallLimit   = 3000;
   // The receiver holds off once for this long so that the block backs up.
   localparam int HoldOff      = 400;
   localparam int HoldAfter    = 60;
   // Counted event beats per random stretch; four stretches make the run.
   localparam int StretchBeats = 440;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [TickWidth-1:0]   csr_wdata;
   int                     failures;
   int                     pending;

   // Bookkeeping on the stimulus side. The tick total mirrors the block's
   // tick counter, so thresholds can be placed a few ticks ahead of it.
   int tick_total;
   int event_count;
   int result_count;
   int send_run;
   bit send_eager;
   int recv_run;
   bit recv_eager;

   espc_req_if req_bus ();
   espc_rsp_if rsp_bus ();

   engine_start_panel_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   espc_checker panel_check (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Each side idles in runs: most runs draw a random idle gap before each beat,
   // and about one run in four goes flat out with no idling at all.
   function automatic int pick_idle(inout int run_left, inout bit run_eager);
      if (run_left == 0) begin
         run_left  = $urandom_range(8, 48);
         run_eager = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      return run_eager ? 0 : int'($urandom_range(0, 9));
   endfunction

   // Offers one event beat and returns right after the edge that took it.
   // Valid stays high when the next beat follows without a gap.
   task automatic send_event(input op_type op, input logic pressed);
      int gap;
      gap = pick_idle(send_run, send_eager);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.pressed   <= pressed;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      event_count++;
      if (op == OP_TICK) tick_total++;
   endtask

   // A threshold write takes one edge with the write enable high.
   task automatic write_register(input csr_idx_type idx, input logic [TickWidth-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Stops offering events and waits until every predicted result beat has
   // come back, then SettleCycles more in case the last event is in flight.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // One release of each button brings the panel back to idle, whatever
   // button was left held; the two that do not match are ignored.
   task automatic release_all();
      send_event(OP_GLOW, 1'b0);
      send_event(OP_START, 1'b0);
      send_event(OP_STOP, 1'b0);
   endtask

   // Random traffic. Most of it is whole press, hold, release sequences with
   // ticks and stray buttons while held; the rest is loose noise and presses
   // that are never released, which leave the panel in a mode that later
   // sequences have to work their way out of. Loose noise is not counted.
   // Once disabled, the panel only answers stop, so most sequences use it.
   task automatic play_traffic(input int budget, input bit disabled);
      int     counted;
      int     pick;
      int     hold;
      op_type button;
      counted = 0;
      while (counted < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            if (disabled && $urandom_range(0, 3) != 0) button = OP_STOP;
            else button = op_type'($urandom_range(0, 2));
            send_event(button, 1'b1);
            hold = $urandom_range(0, 4);
            repeat (hold) begin
               if ($urandom_range(0, 5) == 0)
                  send_event(op_type'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
               else
                  send_event(OP_TICK, 1'($urandom_range(0, 1)));
            end
            send_event(button, 1'b0);
            counted += hold + 2;
         end else if (pick < 93) begin
            send_event(op_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         end else begin
            send_event(op_type'($urandom_range(0, 2)), 1'b1);
            counted++;
         end
      end
   endtask

   // Result side. It stalls per beat like the sender idles, and once, after
   // a fixed number of result beats, it holds ready low for a long stretch
   // while the sender keeps offering, so the block fills and stalls its input.
   initial begin : result_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (result_count == HoldAfter) stall = HoldOff;
         else stall = pick_idle(recv_run, recv_eager);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         result_count++;
      end
   end

   // The watchdog ends a run that stops moving: a lost result beat, a block
   // that never takes an event, or a result channel that never goes valid.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no beat accepted for %0d cycles", StallLimit);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      logic [TickWidth-1:0] bright_mark;
      logic [TickWidth-1:0] dim_mark;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_BRIGHT_TICKS;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_GLOW;
      req_bus.pressed   <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Bright phase with both thresholds at their maximum. Their sum needs
      // the 33rd bit, so a 32-bit sum would be caught here and below.
      write_register(CSR_BRIGHT_TICKS, '1);
      write_register(CSR_DIM_TICKS, '1);

      // Directed beats: every mode entered and left, and the presses and
      // releases that must be ignored in each mode.
      send_event(OP_STOP, 1'b1);    // stop with the power LED bright
      send_event(OP_GLOW, 1'b1);    // press outside idle is ignored
      send_event(OP_TICK, 1'b1);    // the pressed bit means nothing on a tick
      send_event(OP_STOP, 1'b0);    // back to idle, LEDs jump
      send_event(OP_STOP, 1'b0);    // release in idle is ignored
      send_event(OP_GLOW, 1'b1);
      send_event(OP_GLOW, 1'b1);    // repeated press is ignored
      send_event(OP_START, 1'b0);   // release of another button is ignored
      send_event(OP_STOP, 1'b1);    // stop is refused while glowing
      send_event(OP_TICK, 1'b0);
      send_event(OP_GLOW, 1'b0);
      send_event(OP_START, 1'b1);
      send_event(OP_GLOW, 1'b0);    // wrong release while starting
      send_event(OP_START, 1'b0);
      send_event(OP_GLOW, 1'b0);    // release in idle is ignored
      send_event(OP_TICK, 1'b1);
      play_traffic(StretchBeats, 1'b0);
      drain_results();

      // A small dim time next to the largest bright time: a wrapped sum
      // would disable the panel within a few ticks.
      write_register(CSR_DIM_TICKS, 32'd16);
      play_traffic(StretchBeats, 1'b0);
      release_all();
      drain_results();

      // Bright ends a few ticks ahead while the panel is idle, so the phase
      // change itself gives a result beat that fades to the dim levels.
      bright_mark = TickWidth'(tick_total + 4);
      write_register(CSR_BRIGHT_TICKS, bright_mark);
      write_register(CSR_DIM_TICKS, '1);
      while (tick_total < bright_mark) send_event(OP_TICK, 1'($urandom_range(0, 1)));
      drain_results();

      // Raising bright again must not move the phase back, and a zero dim
      // time still leaves the sum far ahead of the counter.
      write_register(CSR_BRIGHT_TICKS, '1);
      write_register(CSR_DIM_TICKS, '0);
      play_traffic(StretchBeats, 1'b0);
      release_all();
      drain_results();

      // Disabled arrives while stop is held: no beat for the phase change,
      // then the release jumps to the disabled idle levels. From then on
      // glow and start presses are refused.
      dim_mark = TickWidth'(tick_total + 6);
      write_register(CSR_BRIGHT_TICKS, '0);
      write_register(CSR_DIM_TICKS, dim_mark);
      send_event(OP_STOP, 1'b1);
      while (tick_total < dim_mark) send_event(OP_TICK, 1'($urandom_range(0, 1)));
      send_event(OP_STOP, 1'b0);
      send_event(OP_GLOW, 1'b1);
      send_event(OP_START, 1'b1);
      send_event(OP_TICK, 1'b0);
      play_traffic(StretchBeats, 1'b1);
      drain_results();

      $display("Covered %0d event beats (%0d ticks) and %0d result beats", event_count,
               tick_total, result_count);
      $display("through the bright, dim and disabled phases with both threshold extremes.");
      if (failures == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
